>>> design/rau_pkg.sv
// Shared constants, command codes and status types for the rational arithmetic unit.
`default_nettype none

package rau_pkg;

    // Default arithmetic word width and fixed port field widths.
    localparam int WORD_BITS_DEF = 32;
    localparam int FIELD_BITS    = 32;
    localparam int DEN_BITS      = 31;
    localparam int OP_BITS       = 3;
    localparam int STATUS_BITS   = 2;

    // Operation codes.
    localparam logic [OP_BITS-1:0] OP_ADD = 3'd0;
    localparam logic [OP_BITS-1:0] OP_SUB = 3'd1;
    localparam logic [OP_BITS-1:0] OP_MUL = 3'd2;
    localparam logic [OP_BITS-1:0] OP_DIV = 3'd3;
    localparam logic [OP_BITS-1:0] OP_EQ  = 3'd4;
    localparam logic [OP_BITS-1:0] OP_LT  = 3'd5;

    // Result status codes.
    localparam logic [STATUS_BITS-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_DIV_ZERO = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_OVERFLOW = 2'd3;

    // Commands from the controller to the datapath.
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_START_A,
        CMD_SAVE_A,
        CMD_START_B,
        CMD_SAVE_B,
        CMD_MUL0,
        CMD_MUL1,
        CMD_MUL2,
        CMD_MUL3,
        CMD_COMB,
        CMD_START_R,
        CMD_SAVE_R,
        CMD_FINISH
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic zero_den;
        logic need_reduce;
        logic red_done;
    } dp_status_t;

endpackage

`default_nettype wire

>>> design/rau_reduce.sv
// Fraction reducer: binary GCD followed by two parallel restoring divisions.
`default_nettype none

module rau_reduce #(
    parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [2*WORD_BITS-1:0] p_in,
    input  wire logic [2*WORD_BITS-1:0] q_in,
    output logic                        done,
    output logic [2*WORD_BITS-1:0]      p_out,
    output logic [2*WORD_BITS-1:0]      q_out
);
    import rau_pkg::*;

    localparam int DW = 2 * WORD_BITS;
    localparam int KW = $clog2(DW + 1);

    typedef enum logic [1:0] {
        R_IDLE,
        R_GCD,
        R_DIV
    } rstate_t;

    rstate_t         state_reg;
    logic            done_reg;
    logic [KW-1:0]   cnt_reg;
    logic [KW-1:0]   k_reg;
    logic [DW-1:0]   x_reg;
    logic [DW-1:0]   y_reg;
    logic [DW-1:0]   g_reg;
    logic [DW-1:0]   pq_reg;
    logic [DW-1:0]   qq_reg;
    logic [DW-1:0]   pr_reg;
    logic [DW-1:0]   qr_reg;

    logic            gcd_end;
    logic            div_last;
    logic [DW:0]     p_trial;
    logic [DW:0]     q_trial;
    logic            p_ge;
    logic            q_ge;
    logic [DW-1:0]   pr_next;
    logic [DW-1:0]   qr_next;

    // GCD ends once either operand reaches zero; division runs DW steps.
    assign gcd_end  = (x_reg == '0) || (y_reg == '0);
    assign div_last = (cnt_reg == KW'(DW - 1));

    // One restoring division step for each of the two dividends.
    always_comb
    begin
        p_trial = {pr_reg, pq_reg[DW-1]};
        q_trial = {qr_reg, qq_reg[DW-1]};
        p_ge    = (p_trial >= {1'b0, g_reg});
        q_ge    = (q_trial >= {1'b0, g_reg});
        pr_next = p_ge ? DW'(p_trial - {1'b0, g_reg}) : p_trial[DW-1:0];
        qr_next = q_ge ? DW'(q_trial - {1'b0, g_reg}) : q_trial[DW-1:0];
    end

    // Sequencer state and the completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                R_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= R_GCD;
                    end
                end
                R_GCD:
                begin
                    if (gcd_end)
                    begin
                        state_reg <= R_DIV;
                    end
                end
                R_DIV:
                begin
                    if (div_last)
                    begin
                        state_reg <= R_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= R_IDLE;
                end
            endcase
        end
    end

    // Working registers of the GCD and the dividers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            R_IDLE:
            begin
                if (start)
                begin
                    x_reg  <= p_in;
                    y_reg  <= q_in;
                    pq_reg <= p_in;
                    qq_reg <= q_in;
                    k_reg  <= '0;
                end
            end
            R_GCD:
            begin
                if (gcd_end)
                begin
                    g_reg   <= ((x_reg == '0) ? y_reg : x_reg) << k_reg;
                    cnt_reg <= '0;
                    pr_reg  <= '0;
                    qr_reg  <= '0;
                end
                else if (!x_reg[0] && !y_reg[0])
                begin
                    x_reg <= x_reg >> 1;
                    y_reg <= y_reg >> 1;
                    k_reg <= k_reg + 1'b1;
                end
                else if (!x_reg[0])
                begin
                    x_reg <= x_reg >> 1;
                end
                else if (!y_reg[0])
                begin
                    y_reg <= y_reg >> 1;
                end
                else if (x_reg >= y_reg)
                begin
                    x_reg <= x_reg - y_reg;
                end
                else
                begin
                    y_reg <= y_reg - x_reg;
                end
            end
            R_DIV:
            begin
                pr_reg  <= pr_next;
                qr_reg  <= qr_next;
                pq_reg  <= {pq_reg[DW-2:0], p_ge};
                qq_reg  <= {qq_reg[DW-2:0], q_ge};
                cnt_reg <= cnt_reg + 1'b1;
            end
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

    assign done  = done_reg;
    assign p_out = pq_reg;
    assign q_out = qq_reg;

endmodule

`default_nettype wire

>>> design/rau_datapath.sv
// Datapath: operand registers, shared multiplier, combine logic and result registers.
`default_nettype none

module rau_datapath #(
    parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire rau_pkg::cmd_t                        cmd,
    input  wire logic [rau_pkg::OP_BITS-1:0]          op,
    input  wire logic [rau_pkg::FIELD_BITS-1:0]       a_num,
    input  wire logic [rau_pkg::FIELD_BITS-1:0]       a_den,
    input  wire logic [rau_pkg::FIELD_BITS-1:0]       b_num,
    input  wire logic [rau_pkg::FIELD_BITS-1:0]       b_den,
    output rau_pkg::dp_status_t                       status_o,
    output logic [rau_pkg::FIELD_BITS-1:0]            res_num,
    output logic [rau_pkg::DEN_BITS-1:0]              res_den,
    output logic                                      compare_true,
    output logic [rau_pkg::STATUS_BITS-1:0]           status
);
    import rau_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int DW = 2 * WORD_BITS;

    logic [OP_BITS-1:0]     op_reg;
    logic                   zero_den_reg;
    logic                   a_sgn_reg;
    logic                   b_sgn_reg;
    logic [W-1:0]           a_mag_reg;
    logic [W-1:0]           a_den_reg;
    logic [W-1:0]           b_mag_reg;
    logic [W-1:0]           b_den_reg;
    logic [DW-1:0]          t1_reg;
    logic [DW-1:0]          t2_reg;
    logic [DW-1:0]          pd_reg;
    logic [DW-1:0]          pm_reg;
    logic                   r_neg_reg;
    logic [DW-1:0]          r_mag_reg;
    logic [DW-1:0]          r_den_reg;
    logic                   cmp_reg;
    logic [FIELD_BITS-1:0]  res_num_reg;
    logic [DEN_BITS-1:0]    res_den_reg;
    logic                   cmp_out_reg;
    logic [STATUS_BITS-1:0] status_reg;

    logic [W-1:0]           an_w;
    logic [W-1:0]           ad_w;
    logic [W-1:0]           bn_w;
    logic [W-1:0]           bd_w;
    logic                   a_neg;
    logic                   b_neg;
    logic                   s1;
    logic                   s2;
    logic                   div_zero;
    logic                   need_reduce;
    logic [W-1:0]           mul_x;
    logic [W-1:0]           mul_y;
    logic [DW-1:0]          prod;
    logic                   red_start;
    logic [DW-1:0]          red_p;
    logic [DW-1:0]          red_q;
    logic                   red_done;
    logic [DW-1:0]          red_p_out;
    logic [DW-1:0]          red_q_out;
    logic                   r_neg_next;
    logic [DW-1:0]          r_mag_next;
    logic [DW-1:0]          r_den_next;
    logic [DW-1:0]          lhs;
    logic [DW-1:0]          rhs;
    logic                   eq_flag;
    logic                   lt_flag;
    logic                   cmp_next;
    logic                   overflow;
    logic [FIELD_BITS-1:0]  mag_field;
    logic                   out_neg;
    logic [STATUS_BITS-1:0] status_next;

    // Operands are the low word bits of each field, taken as two's complement.
    assign an_w = a_num[W-1:0];
    assign ad_w = a_den[W-1:0];
    assign bn_w = b_num[W-1:0];
    assign bd_w = b_den[W-1:0];

    // Sign of a reduced operand; a zero numerator is never negative.
    assign a_neg       = a_sgn_reg && (a_mag_reg != '0);
    assign b_neg       = b_sgn_reg && (b_mag_reg != '0);
    assign div_zero    = (op_reg == OP_DIV) && (b_mag_reg == '0);
    assign need_reduce = (op_reg <= OP_DIV) && !div_zero;

    assign status_o.zero_den    = zero_den_reg;
    assign status_o.need_reduce = need_reduce;
    assign status_o.red_done    = red_done;

    // Shared multiplier operand selection.
    always_comb
    begin
        case (cmd)
            CMD_MUL0:
            begin
                mul_x = a_mag_reg;
                mul_y = b_den_reg;
            end
            CMD_MUL1:
            begin
                mul_x = b_mag_reg;
                mul_y = a_den_reg;
            end
            CMD_MUL2:
            begin
                mul_x = a_den_reg;
                mul_y = b_den_reg;
            end
            default:
            begin
                mul_x = a_mag_reg;
                mul_y = b_mag_reg;
            end
        endcase
    end

    assign prod = mul_x * mul_y;

    // Reducer operand selection.
    always_comb
    begin
        red_start = 1'b0;
        red_p     = {{W{1'b0}}, a_mag_reg};
        red_q     = {{W{1'b0}}, a_den_reg};
        case (cmd)
            CMD_START_A:
            begin
                red_start = 1'b1;
            end
            CMD_START_B:
            begin
                red_start = 1'b1;
                red_p     = {{W{1'b0}}, b_mag_reg};
                red_q     = {{W{1'b0}}, b_den_reg};
            end
            CMD_START_R:
            begin
                red_start = 1'b1;
                red_p     = r_mag_reg;
                red_q     = r_den_reg;
            end
            default:
            begin
                red_start = 1'b0;
            end
        endcase
    end

    rau_reduce #(
        .WORD_BITS (WORD_BITS)
    ) u_reduce (
        .clk   (clk),
        .rst_n (rst_n),
        .start (red_start),
        .p_in  (red_p),
        .q_in  (red_q),
        .done  (red_done),
        .p_out (red_p_out),
        .q_out (red_q_out)
    );

    // Exact result fraction from the cross products.
    always_comb
    begin
        s1         = a_neg;
        s2         = (op_reg == OP_SUB) ? !b_neg : b_neg;
        r_neg_next = r_neg_reg;
        r_mag_next = r_mag_reg;
        r_den_next = r_den_reg;
        case (op_reg)
            OP_ADD, OP_SUB:
            begin
                r_den_next = pd_reg;
                if (s1 == s2)
                begin
                    r_mag_next = t1_reg + t2_reg;
                    r_neg_next = s1;
                end
                else if (t1_reg >= t2_reg)
                begin
                    r_mag_next = t1_reg - t2_reg;
                    r_neg_next = s1;
                end
                else
                begin
                    r_mag_next = t2_reg - t1_reg;
                    r_neg_next = s2;
                end
            end
            OP_MUL:
            begin
                r_mag_next = pm_reg;
                r_den_next = pd_reg;
                r_neg_next = a_neg ^ b_neg;
            end
            OP_DIV:
            begin
                r_mag_next = t1_reg;
                r_den_next = t2_reg;
                r_neg_next = a_neg ^ b_neg;
            end
            default:
            begin
                r_neg_next = r_neg_reg;
            end
        endcase
    end

    // Exact compares on the reduced operands and their cross products.
    always_comb
    begin
        lhs      = a_neg ? DW'(0) - t1_reg : t1_reg;
        rhs      = b_neg ? DW'(0) - t2_reg : t2_reg;
        eq_flag  = (a_neg == b_neg) && (a_mag_reg == b_mag_reg) && (a_den_reg == b_den_reg);
        lt_flag  = ($signed(lhs) < $signed(rhs));
        cmp_next = ((op_reg == OP_EQ) && eq_flag) || ((op_reg == OP_LT) && lt_flag);
    end

    // Final status and result fields.
    always_comb
    begin
        overflow  = (|r_mag_reg[DW-1:W-1]) || (|r_den_reg[DW-1:W-1]);
        mag_field = FIELD_BITS'(r_mag_reg[W-2:0]);
        out_neg   = r_neg_reg && (r_mag_reg != '0);
        if (zero_den_reg)
        begin
            status_next = ST_ZERO_DEN;
        end
        else if (div_zero)
        begin
            status_next = ST_DIV_ZERO;
        end
        else if (need_reduce && overflow)
        begin
            status_next = ST_OVERFLOW;
        end
        else
        begin
            status_next = ST_OK;
        end
    end

    // Command-driven register updates.
    always_ff @(posedge clk)
    begin
        case (cmd)
            CMD_LOAD:
            begin
                op_reg       <= op;
                zero_den_reg <= (ad_w == '0) || (bd_w == '0);
                a_sgn_reg    <= an_w[W-1] ^ ad_w[W-1];
                b_sgn_reg    <= bn_w[W-1] ^ bd_w[W-1];
                a_mag_reg    <= an_w[W-1] ? W'(0) - an_w : an_w;
                a_den_reg    <= ad_w[W-1] ? W'(0) - ad_w : ad_w;
                b_mag_reg    <= bn_w[W-1] ? W'(0) - bn_w : bn_w;
                b_den_reg    <= bd_w[W-1] ? W'(0) - bd_w : bd_w;
            end
            CMD_SAVE_A:
            begin
                a_mag_reg <= red_p_out[W-1:0];
                a_den_reg <= red_q_out[W-1:0];
            end
            CMD_SAVE_B:
            begin
                b_mag_reg <= red_p_out[W-1:0];
                b_den_reg <= red_q_out[W-1:0];
            end
            CMD_MUL0:
            begin
                t1_reg <= prod;
            end
            CMD_MUL1:
            begin
                t2_reg <= prod;
            end
            CMD_MUL2:
            begin
                pd_reg <= prod;
            end
            CMD_MUL3:
            begin
                pm_reg <= prod;
            end
            CMD_COMB:
            begin
                r_neg_reg <= r_neg_next;
                r_mag_reg <= r_mag_next;
                r_den_reg <= r_den_next;
                cmp_reg   <= cmp_next;
            end
            CMD_SAVE_R:
            begin
                r_mag_reg <= red_p_out;
                r_den_reg <= red_q_out;
            end
            CMD_FINISH:
            begin
                status_reg  <= status_next;
                cmp_out_reg <= !zero_den_reg && cmp_reg;
                if (status_next == ST_OK && need_reduce)
                begin
                    res_num_reg <= out_neg ? FIELD_BITS'(0) - mag_field : mag_field;
                    res_den_reg <= DEN_BITS'(r_den_reg[W-2:0]);
                end
                else
                begin
                    res_num_reg <= '0;
                    res_den_reg <= DEN_BITS'(1);
                end
            end
            default:
            begin
                op_reg <= op_reg;
            end
        endcase
    end

    assign res_num      = res_num_reg;
    assign res_den      = res_den_reg;
    assign compare_true = cmp_out_reg;
    assign status       = status_reg;

endmodule

`default_nettype wire

>>> design/rau_ctrl.sv
// Controller state machine sequencing the datapath for one transaction at a time.
`default_nettype none

module rau_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    input  wire rau_pkg::dp_status_t dp_status,
    output rau_pkg::cmd_t            cmd
);
    import rau_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_WAIT_A,
        S_START_B,
        S_WAIT_B,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_COMB,
        S_START_R,
        S_WAIT_R,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_free;

    // The output register can take a new result when empty or being drained.
    assign out_free = !out_valid_reg || m_tready;

    // Next state and the command for the datapath.
    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd        = CMD_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (dp_status.zero_den)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd        = CMD_START_A;
                    state_next = S_WAIT_A;
                end
            end
            S_WAIT_A:
            begin
                if (dp_status.red_done)
                begin
                    cmd        = CMD_SAVE_A;
                    state_next = S_START_B;
                end
            end
            S_START_B:
            begin
                cmd        = CMD_START_B;
                state_next = S_WAIT_B;
            end
            S_WAIT_B:
            begin
                if (dp_status.red_done)
                begin
                    cmd        = CMD_SAVE_B;
                    state_next = S_MUL0;
                end
            end
            S_MUL0:
            begin
                cmd        = CMD_MUL0;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                cmd        = CMD_MUL1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd        = CMD_MUL2;
                state_next = S_MUL3;
            end
            S_MUL3:
            begin
                cmd        = CMD_MUL3;
                state_next = S_COMB;
            end
            S_COMB:
            begin
                cmd        = CMD_COMB;
                state_next = S_START_R;
            end
            S_START_R:
            begin
                if (dp_status.need_reduce)
                begin
                    cmd        = CMD_START_R;
                    state_next = S_WAIT_R;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_WAIT_R:
            begin
                if (dp_status.red_done)
                begin
                    cmd        = CMD_SAVE_R;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd        = CMD_FINISH;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd == CMD_FINISH)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

`default_nettype wire

>>> design/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit: controller, datapath and checks.
//
// Usage:
// - Input stream s_*: one transaction carries two fractions (a_num/a_den,
//   b_num/b_den in s_tdata) and the operation code in s_tuser.
// - Output stream m_*: one transaction per input with the reduced fraction
//   and compare bit in m_tdata and the status code in m_tuser.
// - Each operand is reduced by a binary GCD plus two parallel restoring
//   divisions of 2*WORD_BITS steps; arithmetic results go through the same
//   reducer once more. The single shared reducer sets the latency. Compares
//   and division by a zero fraction skip the last reduction. A GCD takes
//   up to 4*WORD_BITS steps for an operand and 8*WORD_BITS for the result,
//   usually far fewer. A zero denominator skips all reductions.
// - One transaction is worked on at a time; s_tready is high only when the
//   unit is idle. The result register lets a new transaction be accepted
//   while the previous result still waits on m_tready.
// - Reset clears the controller and the output valid flag; no state from a
//   transaction carries into the next.
// - When the receiver stalls, the result holds and the unit waits for the
//   output register to free before it delivers the next result.
`default_nettype none

module rational_arithmetic_unit #(
    parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // a_num [31:0], a_den [63:32], b_num [95:64], b_den [127:96]
    input  wire logic [127:0] s_tdata,
    // op [2:0]
    input  wire logic [2:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // res_num [31:0], res_den [62:32], compare_true [63]
    output logic [63:0]       m_tdata,
    // status [1:0]
    output logic [1:0]        m_tuser
);
    import rau_pkg::*;

    cmd_t                   cmd;
    dp_status_t             dp_status;
    logic [FIELD_BITS-1:0]  res_num;
    logic [DEN_BITS-1:0]    res_den;
    logic                   compare_true;
    logic [STATUS_BITS-1:0] status;

    rau_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    rau_datapath #(
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .op           (s_tuser),
        .a_num        (s_tdata[31:0]),
        .a_den        (s_tdata[63:32]),
        .b_num        (s_tdata[95:64]),
        .b_den        (s_tdata[127:96]),
        .status_o     (dp_status),
        .res_num      (res_num),
        .res_den      (res_den),
        .compare_true (compare_true),
        .status       (status)
    );

    assign m_tdata = {compare_true, res_den, res_num};
    assign m_tuser = status;

`ifndef SYNTHESIS
    // A delivered denominator is never zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[62:32] != '0))
        else $error("result denominator is zero");

    // Any error status comes with the fraction 0/1.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != ST_OK)) |-> ((m_tdata[31:0] == '0) && (m_tdata[62:32] == 31'd1)))
        else $error("error result is not 0/1");

    // A true compare comes with status ok and a denominator of 1.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[63]) |-> ((m_tuser == ST_OK) && (m_tdata[62:32] == 31'd1)))
        else $error("compare result carries a fraction or an error");

    // No input is taken in the cycle a result is loaded.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == CMD_FINISH) |-> !s_tready)
        else $error("input accepted while a result is written");
`endif

endmodule

`default_nettype wire
